### rtl/rtc_date_register_encoder_top_macros.svh
// ----------------------------------------------------------------------------
// RTC date register encoder assertion macros
// Concurrent check wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef RTC_DATE_REGISTER_ENCODER_TOP_MACROS_SVH
`define RTC_DATE_REGISTER_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RTCDE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rtcde check failed");
`define RTCDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtcde check failed");
`else
`define RTCDE_ASSERT(lbl, clk, rst_n, prop)
`define RTCDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/rtcde_pkg.sv
// ----------------------------------------------------------------------------
// RTC date register encoder package
// Shared constants and conversion functions.
// ----------------------------------------------------------------------------
package rtcde_pkg;

  localparam logic [11:0] CENTURY_YEAR    = 12'd2000;
  localparam logic [3:0]  MONTH_EARLY_MAX = 4'd2;
  localparam logic [2:0]  WEEKDAY_BASE    = 3'd1;

  // (31 * m) / 12 for the March-based month index, by calendar month
  localparam logic [5:0] MONTH_OFF [0:15] = '{
    6'd25, 6'd28, 6'd31, 6'd2,  6'd5,  6'd7,  6'd10, 6'd12,
    6'd15, 6'd18, 6'd20, 6'd23, 6'd25, 6'd28, 6'd31, 6'd33
  };

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  d;
    p = {8'd0, v} * 15'd205;
    t = p[14:11];
    d = v - {3'd0, t} * 7'd10;
    return {t, d[3:0]};
  endfunction

  function automatic logic [5:0] div100(input logic [11:0] y);
    logic [24:0] p;
    p = {13'd0, y} * 25'd5243;
    return p[24:19];
  endfunction

  function automatic logic [2:0] mod7(input logic [12:0] s);
    logic [26:0] p;
    logic [9:0]  q;
    logic [12:0] r;
    p = {14'd0, s} * 27'd9363;
    q = p[25:16];
    r = s - {3'd0, q} * 13'd7;
    return r[2:0];
  endfunction

endpackage

### rtl/rtc_date_register_encoder_top.sv
// ----------------------------------------------------------------------------
// RTC date register encoder
// The strobe rises together with the result; both come from the result stage.
// Throughput: one item per cycle; busy is high only while in reset.
// Four register stages (input, divide, sum, result) set the latency.
// Reset clears the stage valid bits; no result is pending after reset.
// Results are never held off; each strobes for exactly one cycle.
// ----------------------------------------------------------------------------
`include "rtc_date_register_encoder_top_macros.svh"

module rtc_date_register_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_seconds,
  input  logic [5:0]  in_minutes,
  input  logic [4:0]  in_hours,
  input  logic [4:0]  in_day_of_month,
  input  logic [3:0]  in_month_number,
  input  logic [11:0] in_full_year,
  output logic        out_strobe,
  output logic [7:0]  out_seconds_bcd,
  output logic [7:0]  out_minutes_bcd,
  output logic [7:0]  out_hours_bcd,
  output logic [2:0]  out_weekday,
  output logic [7:0]  out_date_bcd,
  output logic [7:0]  out_month_century,
  output logic [7:0]  out_year_bcd
);
  import rtcde_pkg::*;

  logic        accept;
  logic        vld0_r;
  logic        vld1_r;
  logic        vld2_r;
  logic        strobe_r;
  logic [5:0]  sec_r;
  logic [5:0]  min_r;
  logic [4:0]  hr_r;
  logic [4:0]  date_r;
  logic [3:0]  month_r;
  logic [11:0] year_r;
  logic [7:0]  s1_sec_r;
  logic [7:0]  s1_min_r;
  logic [7:0]  s1_hr_r;
  logic [7:0]  s1_date_r;
  logic [7:0]  s1_mon_r;
  logic [11:0] s1_year_r;
  logic [5:0]  s1_yq_r;
  logic [7:0]  s2_sec_r;
  logic [7:0]  s2_min_r;
  logic [7:0]  s2_hr_r;
  logic [7:0]  s2_date_r;
  logic [7:0]  s2_mon_r;
  logic [11:0] s2_rem_full;
  logic [6:0]  s2_rem_r;
  logic [7:0]  sec_out_r;
  logic [7:0]  min_out_r;
  logic [7:0]  hr_out_r;
  logic [7:0]  date_out_r;
  logic [7:0]  mon_out_r;
  logic [7:0]  year_out_r;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r   <= 1'b0;
      vld1_r   <= 1'b0;
      vld2_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld0_r   <= accept;
      vld1_r   <= vld0_r;
      vld2_r   <= vld1_r;
      strobe_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    sec_r   <= in_seconds;
    min_r   <= in_minutes;
    hr_r    <= in_hours;
    date_r  <= in_day_of_month;
    month_r <= in_month_number;
    year_r  <= in_full_year;
  end

  always_ff @(posedge clk) begin
    s1_sec_r  <= to_bcd({1'b0, sec_r});
    s1_min_r  <= to_bcd({1'b0, min_r});
    s1_hr_r   <= to_bcd({2'b0, hr_r});
    s1_date_r <= to_bcd({2'b0, date_r});
    s1_mon_r  <= {(year_r >= CENTURY_YEAR), 7'd0} | to_bcd({3'b0, month_r});
    s1_year_r <= year_r;
    s1_yq_r   <= div100(year_r);
  end

  assign s2_rem_full = s1_year_r - {6'd0, s1_yq_r} * 12'd100;

  always_ff @(posedge clk) begin
    s2_sec_r  <= s1_sec_r;
    s2_min_r  <= s1_min_r;
    s2_hr_r   <= s1_hr_r;
    s2_date_r <= s1_date_r;
    s2_mon_r  <= s1_mon_r;
    s2_rem_r  <= s2_rem_full[6:0];
  end

  always_ff @(posedge clk) begin
    sec_out_r  <= s2_sec_r;
    min_out_r  <= s2_min_r;
    hr_out_r   <= s2_hr_r;
    date_out_r <= s2_date_r;
    mon_out_r  <= s2_mon_r;
    year_out_r <= to_bcd(s2_rem_r);
  end

  rtcde_weekday u_weekday (
    .clk       (clk),
    .date_i    (date_r),
    .month_i   (month_r),
    .year_i    (year_r),
    .weekday_o (out_weekday)
  );

  assign out_strobe        = strobe_r;
  assign out_seconds_bcd   = sec_out_r;
  assign out_minutes_bcd   = min_out_r;
  assign out_hours_bcd     = hr_out_r;
  assign out_date_bcd      = date_out_r;
  assign out_month_century = mon_out_r;
  assign out_year_bcd      = year_out_r;

  `RTCDE_ASSERT_IMP(a_strobe_has_accept, clk, rst_n, out_strobe, $past(accept, 4))
  `RTCDE_ASSERT_IMP(a_accept_gives_strobe, clk, rst_n, accept, ##4 out_strobe)
  `RTCDE_ASSERT_IMP(a_weekday_range, clk, rst_n, out_strobe, (out_weekday >= 3'd1) && (out_weekday <= 3'd7))
  `RTCDE_ASSERT_IMP(a_year_digits, clk, rst_n, out_strobe, (out_year_bcd[7:4] <= 4'd9) && (out_year_bcd[3:0] <= 4'd9))
  `RTCDE_ASSERT_IMP(a_century_bit, clk, rst_n, out_strobe, out_month_century[7] == ($past(in_full_year, 4) >= CENTURY_YEAR))

endmodule

### rtl/rtcde_weekday.sv
// ----------------------------------------------------------------------------
// RTC date register encoder weekday pipeline
// Gregorian day of week in three register stages, 1 = Sunday.
// ----------------------------------------------------------------------------
module rtcde_weekday (
  input  logic        clk,
  input  logic [4:0]  date_i,
  input  logic [3:0]  month_i,
  input  logic [11:0] year_i,
  output logic [2:0]  weekday_o
);
  import rtcde_pkg::*;

  logic        early;
  logic [11:0] y_adj;
  logic [4:0]  s1_date_r;
  logic [11:0] s1_y_r;
  logic [5:0]  s1_q100_r;
  logic [5:0]  s1_off_r;
  logic [12:0] s2_sum_nxt;
  logic [12:0] s2_sum_r;
  logic [2:0]  weekday_r;

  always_comb begin
    early = (month_i <= MONTH_EARLY_MAX);
    if (early && (year_i != 12'd0)) begin
      y_adj = year_i - 12'd1;
    end else begin
      y_adj = year_i;
    end
  end

  always_ff @(posedge clk) begin
    s1_date_r <= date_i;
    s1_y_r    <= y_adj;
    s1_q100_r <= div100(y_adj);
    s1_off_r  <= MONTH_OFF[month_i];
  end

  assign s2_sum_nxt = {8'd0, s1_date_r} + {1'b0, s1_y_r} + {3'd0, s1_y_r[11:2]}
                    - {7'd0, s1_q100_r} + {9'd0, s1_q100_r[5:2]} + {7'd0, s1_off_r};

  always_ff @(posedge clk) begin
    s2_sum_r  <= s2_sum_nxt;
    weekday_r <= mod7(s2_sum_r) + WEEKDAY_BASE;
  end

  assign weekday_o = weekday_r;

endmodule
